### hdl/vva_pkg.sv
// ----------------------------------------------------------------------------
// vva_pkg
// Shared widths, codes, payload types and arithmetic helpers of the
// three-component vector ALU.
// ----------------------------------------------------------------------------
package vva_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int MW   = W + 2;          // multiplier operand width
    localparam int XW   = 2 * W + 4;      // exact product / sum width
    localparam int NUMW = W + F + 1;      // scaled dividend width
    localparam int REMW = W + 2;          // partial remainder width

    typedef logic signed [W-1:0] word_t;

    localparam word_t ONE_FX = word_t'(64'd1 << F);
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] XMAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] XMIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] HALF_X = XW'(1) << (F - 1);

    localparam logic [3:0] FUNC_DOT    = 4'd0;
    localparam logic [3:0] FUNC_SCALE  = 4'd1;
    localparam logic [3:0] FUNC_DIV    = 4'd2;
    localparam logic [3:0] FUNC_ADD    = 4'd3;
    localparam logic [3:0] FUNC_SUB    = 4'd4;
    localparam logic [3:0] FUNC_NEG    = 4'd5;
    localparam logic [3:0] FUNC_LEN    = 4'd6;
    localparam logic [3:0] FUNC_NORM   = 4'd7;
    localparam logic [3:0] FUNC_CROSS  = 4'd8;
    localparam logic [3:0] FUNC_LERP   = 4'd9;

    typedef enum logic [3:0] {
        OP_DOT, OP_SCALE, OP_DIV, OP_ADD, OP_SUB, OP_NEG,
        OP_LEN, OP_NORM, OP_CROSS, OP_LERP, OP_NONE
    } op_t;

    typedef struct packed {
        logic [3:0] func;
        word_t      ax;
        word_t      ay;
        word_t      az;
        word_t      bx;
        word_t      by;
        word_t      bz;
        word_t      scal;
    } in_t;

    typedef struct packed {
        word_t rx;
        word_t ry;
        word_t rz;
        word_t rscalar;
        logic  div_by_zero;
        logic  saturated;
    } out_t;

    // decoded command handed from the front to the execution pipeline
    typedef struct packed {
        op_t             op;
        logic            lerp_lo;
        logic            lerp_hi;
        logic [2:0][W-1:0] a;
        logic [2:0][W-1:0] b;
        logic [W-1:0]    scal;
    } cmd_t;

    typedef struct packed {
        logic [W-1:0] val;
        logic         flag;
    } sat_t;

    function automatic sat_t sat_word(input logic signed [XW-1:0] v);
        sat_t r;
        if (v > XMAX) begin
            r.val  = WMAX;
            r.flag = 1'b1;
        end else if (v < XMIN) begin
            r.val  = WMIN;
            r.flag = 1'b1;
        end else begin
            r.val  = v[W-1:0];
            r.flag = 1'b0;
        end
        return r;
    endfunction

    // round half up, then arithmetic shift by the fraction width
    function automatic logic signed [XW-1:0] rnd_shift(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = v + HALF_X;
        return t >>> F;
    endfunction

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

### hdl/vva_front.sv
// ----------------------------------------------------------------------------
// vva_front
// Input register: accept items and decode the opcode and lerp bounds.
// ----------------------------------------------------------------------------
module vva_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  vva_pkg::in_t  item,
    output logic          cmd_push,
    input  logic          cmd_full,
    output vva_pkg::cmd_t cmd
);

    logic          valid_reg, valid_next;
    vva_pkg::cmd_t cmd_reg, cmd_next, dec;
    logic          take;

    assign full     = valid_reg && cmd_full;
    assign take     = push && !full;
    assign cmd_push = valid_reg && !cmd_full;
    assign cmd      = cmd_reg;

    always_comb
    begin
        dec      = '0;
        dec.a[0] = item.ax;
        dec.a[1] = item.ay;
        dec.a[2] = item.az;
        dec.b[0] = item.bx;
        dec.b[1] = item.by;
        dec.b[2] = item.bz;
        dec.scal = item.scal;
        dec.lerp_lo = (item.scal <= 0);
        dec.lerp_hi = (item.scal >= vva_pkg::ONE_FX);
        case (item.func)
            vva_pkg::FUNC_DOT:   dec.op = vva_pkg::OP_DOT;
            vva_pkg::FUNC_SCALE: dec.op = vva_pkg::OP_SCALE;
            vva_pkg::FUNC_DIV:   dec.op = vva_pkg::OP_DIV;
            vva_pkg::FUNC_ADD:   dec.op = vva_pkg::OP_ADD;
            vva_pkg::FUNC_SUB:   dec.op = vva_pkg::OP_SUB;
            vva_pkg::FUNC_NEG:   dec.op = vva_pkg::OP_NEG;
            vva_pkg::FUNC_LEN:   dec.op = vva_pkg::OP_LEN;
            vva_pkg::FUNC_NORM:  dec.op = vva_pkg::OP_NORM;
            vva_pkg::FUNC_CROSS: dec.op = vva_pkg::OP_CROSS;
            vva_pkg::FUNC_LERP:  dec.op = vva_pkg::OP_LERP;
            default:             dec.op = vva_pkg::OP_NONE;
        endcase
    end

    assign valid_next = take || (valid_reg && cmd_full);
    assign cmd_next   = take ? dec : cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

### hdl/vva_cmd_queue.sv
// ----------------------------------------------------------------------------
// vva_cmd_queue
// Four-entry queue of decoded commands between front and execution.
// ----------------------------------------------------------------------------
module vva_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  vva_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output vva_pkg::cmd_t rd_data,
    output logic          empty
);

    vva_pkg::cmd_t mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign full    = (cnt_reg == 3'd4);
    assign empty   = (cnt_reg == 3'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + 2'(do_wr);
    assign rd_ptr_next = rd_ptr_reg + 2'(do_rd);
    assign cnt_next    = cnt_reg + 3'(do_wr) - 3'(do_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/vva_back.sv
// ----------------------------------------------------------------------------
// vva_back
// Execution pipeline: multiply, combine, digit-serial square root and
// restoring division stages, then a two-entry result buffer.
// ----------------------------------------------------------------------------
module vva_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  vva_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          empty,
    input  logic          pop,
    output vva_pkg::out_t result
);

    localparam int W    = vva_pkg::W;
    localparam int F    = vva_pkg::F;
    localparam int MW   = vva_pkg::MW;
    localparam int XW   = vva_pkg::XW;
    localparam int NUMW = vva_pkg::NUMW;
    localparam int REMW = vva_pkg::REMW;
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef struct packed {
        vva_pkg::op_t       op;
        logic [2:0][MW-1:0] m0a;
        logic [2:0][MW-1:0] m0b;
        logic [2:0][MW-1:0] m1a;
        logic [2:0][MW-1:0] m1b;
        logic [2:0][W-1:0]  mag;
        logic [2:0]         neg_a;
        logic [2:0][W-1:0]  a;
        logic [2:0][W-1:0]  b;
        logic               lerp_lo;
        logic               lerp_hi;
        logic [2:0][W-1:0]  simp;
        logic               simp_st;
        logic               scal_neg;
        logic [W-1:0]       scal_mag;
    } p1_t;

    typedef struct packed {
        vva_pkg::op_t        op;
        logic [2:0][XW-1:0]  p0;
        logic [2:0][XW-1:0]  p1;
        logic [2:0][2*W-1:0] sq;
        logic [2:0][W-1:0]   mag;
        logic [2:0]          neg_a;
        logic [2:0][W-1:0]   a;
        logic [2:0][W-1:0]   b;
        logic                lerp_lo;
        logic                lerp_hi;
        logic [2:0][W-1:0]   simp;
        logic                simp_st;
        logic                scal_neg;
        logic [W-1:0]        scal_mag;
    } p2_t;

    typedef struct packed {
        vva_pkg::op_t      op;
        logic [2:0][W-1:0] r;
        logic [W-1:0]      rs;
        logic              st;
        logic [2:0][W-1:0] mag;
        logic [2:0]        neg_a;
        logic              scal_neg;
        logic [W-1:0]      scal_mag;
    } pay_t;

    logic en;

    vva_pkg::cmd_t p0_reg;
    logic          p0_v_reg;
    p1_t           p1_reg, p1_next;
    logic          p1_v_reg;
    p2_t           p2_reg, p2_next;
    logic          p2_v_reg;
    pay_t          p3_next;
    logic [2*W-1:0] s_next;

    pay_t           sq_pay_reg  [W+1];
    logic [2*W-1:0] sq_s_reg    [W+1];
    logic [REMW-1:0] sq_rem_reg [W+1];
    logic [W-1:0]   sq_root_reg [W+1];
    logic [W:0]     sq_v_reg;

    pay_t                dv_pay_reg [W+2];
    logic [W:0]          dv_d_reg   [W+2];
    logic                dv_dz_reg  [W+2];
    logic [2:0][REMW-1:0] dv_rem_reg [W+2];
    logic [2:0][W:0]     dv_q_reg   [W+2];
    logic [2:0][W:0]     dv_num_reg [W+2];
    logic [2:0]          dv_ovf_reg [W+2];
    logic [W+1:0]        dv_v_reg;

    pay_t                l_pay_next;
    logic [W:0]          l_d_next;
    logic                l_dz_next;
    logic [2:0][REMW-1:0] l_rem_next;
    logic [2:0][W:0]     l_num_next;
    logic [2:0]          l_ovf_next;

    vva_pkg::out_t fin;
    logic          last_v;

    vva_pkg::out_t ob_reg [2];
    logic          ob_wr_reg, ob_wr_next;
    logic          ob_rd_reg, ob_rd_next;
    logic [1:0]    ob_cnt_reg, ob_cnt_next;
    logic          ob_full, ob_push, ob_pop;

    // the whole pipeline moves as one; hold only when a result cannot leave
    assign last_v  = dv_v_reg[W+1];
    assign ob_full = (ob_cnt_reg == 2'd2);
    assign en      = !last_v || !ob_full;
    assign cmd_pop = en && !cmd_empty;

    // operand selection
    always_comb
    begin
        vva_pkg::sat_t sr;
        logic signed [XW-1:0] xa, xb;
        sr = '0;
        xa = '0;
        xb = '0;
        p1_next          = '0;
        p1_next.op       = p0_reg.op;
        p1_next.a        = p0_reg.a;
        p1_next.b        = p0_reg.b;
        p1_next.lerp_lo  = p0_reg.lerp_lo;
        p1_next.lerp_hi  = p0_reg.lerp_hi;
        p1_next.scal_neg = p0_reg.scal[W-1];
        p1_next.scal_mag = vva_pkg::mag_of(p0_reg.scal);
        for (int i = 0; i < 3; i++)
        begin
            p1_next.mag[i]   = vva_pkg::mag_of(p0_reg.a[i]);
            p1_next.neg_a[i] = p0_reg.a[i][W-1];
            xa = XW'($signed(p0_reg.a[i]));
            xb = XW'($signed(p0_reg.b[i]));
            case (p0_reg.op)
                vva_pkg::OP_DOT:
                begin
                    p1_next.m0a[i] = MW'($signed(p0_reg.a[i]));
                    p1_next.m0b[i] = MW'($signed(p0_reg.b[i]));
                end
                vva_pkg::OP_SCALE:
                begin
                    p1_next.m0a[i] = MW'($signed(p0_reg.a[i]));
                    p1_next.m0b[i] = MW'($signed(p0_reg.scal));
                end
                vva_pkg::OP_CROSS:
                begin
                    p1_next.m0a[i] = MW'($signed(p0_reg.a[NXT[i]]));
                    p1_next.m0b[i] = MW'($signed(p0_reg.b[PRV[i]]));
                    p1_next.m1a[i] = MW'($signed(p0_reg.a[PRV[i]]));
                    p1_next.m1b[i] = MW'($signed(p0_reg.b[NXT[i]]));
                end
                vva_pkg::OP_LERP:
                begin
                    p1_next.m0a[i] = MW'($signed(p0_reg.b[i])) - MW'($signed(p0_reg.a[i]));
                    p1_next.m0b[i] = MW'($signed(p0_reg.scal));
                end
                vva_pkg::OP_ADD:
                begin
                    sr = vva_pkg::sat_word(xa + xb);
                end
                vva_pkg::OP_SUB:
                begin
                    sr = vva_pkg::sat_word(xa - xb);
                end
                vva_pkg::OP_NEG:
                begin
                    sr = vva_pkg::sat_word(-xa);
                end
                default:
                begin
                    sr = '0;
                end
            endcase
            p1_next.simp[i] = sr.val;
            p1_next.simp_st = p1_next.simp_st | sr.flag;
        end
    end

    // products and squares
    always_comb
    begin
        logic signed [XW-1:0] xa, xb, xc, xd;
        logic [2*W-1:0] mg;
        p2_next          = '0;
        p2_next.op       = p1_reg.op;
        p2_next.mag      = p1_reg.mag;
        p2_next.neg_a    = p1_reg.neg_a;
        p2_next.a        = p1_reg.a;
        p2_next.b        = p1_reg.b;
        p2_next.lerp_lo  = p1_reg.lerp_lo;
        p2_next.lerp_hi  = p1_reg.lerp_hi;
        p2_next.simp     = p1_reg.simp;
        p2_next.simp_st  = p1_reg.simp_st;
        p2_next.scal_neg = p1_reg.scal_neg;
        p2_next.scal_mag = p1_reg.scal_mag;
        for (int i = 0; i < 3; i++)
        begin
            xa = XW'($signed(p1_reg.m0a[i]));
            xb = XW'($signed(p1_reg.m0b[i]));
            xc = XW'($signed(p1_reg.m1a[i]));
            xd = XW'($signed(p1_reg.m1b[i]));
            mg = (2*W)'(p1_reg.mag[i]);
            p2_next.p0[i] = xa * xb;
            p2_next.p1[i] = xc * xd;
            p2_next.sq[i] = mg * mg;
        end
    end

    // round, saturate and select the product-based results
    always_comb
    begin
        vva_pkg::sat_t sr;
        logic signed [XW-1:0] acc;
        sr  = '0;
        acc = '0;
        p3_next          = '0;
        p3_next.op       = p2_reg.op;
        p3_next.mag      = p2_reg.mag;
        p3_next.neg_a    = p2_reg.neg_a;
        p3_next.scal_neg = p2_reg.scal_neg;
        p3_next.scal_mag = p2_reg.scal_mag;
        case (p2_reg.op)
            vva_pkg::OP_DOT:
            begin
                acc = $signed(p2_reg.p0[0]) + $signed(p2_reg.p0[1])
                    + $signed(p2_reg.p0[2]);
                sr  = vva_pkg::sat_word(vva_pkg::rnd_shift(acc));
                p3_next.rs = sr.val;
                p3_next.st = sr.flag;
            end
            vva_pkg::OP_SCALE, vva_pkg::OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc = $signed(p2_reg.p0[i]) - $signed(p2_reg.p1[i]);
                    sr  = vva_pkg::sat_word(vva_pkg::rnd_shift(acc));
                    p3_next.r[i] = sr.val;
                    p3_next.st   = p3_next.st | sr.flag;
                end
            end
            vva_pkg::OP_LERP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (p2_reg.lerp_lo)
                    begin
                        p3_next.r[i] = p2_reg.a[i];
                    end
                    else if (p2_reg.lerp_hi)
                    begin
                        p3_next.r[i] = p2_reg.b[i];
                    end
                    else
                    begin
                        acc = XW'($signed(p2_reg.a[i]))
                            + vva_pkg::rnd_shift($signed(p2_reg.p0[i]));
                        sr  = vva_pkg::sat_word(acc);
                        p3_next.r[i] = sr.val;
                        p3_next.st   = p3_next.st | sr.flag;
                    end
                end
            end
            vva_pkg::OP_ADD, vva_pkg::OP_SUB, vva_pkg::OP_NEG:
            begin
                p3_next.r  = p2_reg.simp;
                p3_next.st = p2_reg.simp_st;
            end
            default:
            begin
                p3_next.r = '0;
            end
        endcase
        s_next = p2_reg.sq[0] + p2_reg.sq[1] + p2_reg.sq[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg    <= 1'b0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            p0_v_reg    <= !cmd_empty;
            p1_v_reg    <= p0_v_reg;
            p2_v_reg    <= p1_v_reg;
            sq_v_reg[0] <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg         <= cmd;
            p1_reg         <= p1_next;
            p2_reg         <= p2_next;
            sq_pay_reg[0]  <= p3_next;
            sq_s_reg[0]    <= s_next;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        logic [REMW-1:0] rsh, trial;
        logic            ge;
        assign rsh   = {sq_rem_reg[k][REMW-3:0], sq_s_reg[k][2*(W-1-k)+1 -: 2]};
        assign trial = {sq_root_reg[k], 2'b01};
        assign ge    = (rsh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_pay_reg[k+1]  <= sq_pay_reg[k];
                sq_s_reg[k+1]    <= sq_s_reg[k];
                sq_rem_reg[k+1]  <= ge ? (rsh - trial) : rsh;
                sq_root_reg[k+1] <= {sq_root_reg[k][W-2:0], ge};
            end
        end
    end

    // round the length, pick the divisor, scale the dividends
    always_comb
    begin
        logic [W:0]      len;
        logic [NUMW-1:0] num;
        len = (W+1)'(sq_root_reg[W])
            + (W+1)'(sq_rem_reg[W] > REMW'(sq_root_reg[W]));
        num = '0;
        l_pay_next = sq_pay_reg[W];
        if (sq_pay_reg[W].op == vva_pkg::OP_LEN)
        begin
            if (len[W] || len[W-1])
            begin
                l_pay_next.rs = vva_pkg::WMAX;
                l_pay_next.st = 1'b1;
            end
            else
            begin
                l_pay_next.rs = len[W-1:0];
            end
        end
        l_d_next  = (sq_pay_reg[W].op == vva_pkg::OP_NORM) ? len
                    : (W+1)'(sq_pay_reg[W].scal_mag);
        l_dz_next = (l_d_next == '0);
        for (int i = 0; i < 3; i++)
        begin
            num = (NUMW'(sq_pay_reg[W].mag[i]) << F) + NUMW'(l_d_next >> 1);
            l_rem_next[i] = REMW'(num >> (W + 1));
            l_ovf_next[i] = (l_rem_next[i] >= REMW'(l_d_next));
            l_num_next[i] = num[W:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= sq_v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_pay_reg[0] <= l_pay_next;
            dv_d_reg[0]   <= l_d_next;
            dv_dz_reg[0]  <= l_dz_next;
            dv_rem_reg[0] <= l_rem_next;
            dv_q_reg[0]   <= '0;
            dv_num_reg[0] <= l_num_next;
            dv_ovf_reg[0] <= l_ovf_next;
        end
    end

    // restoring division, one quotient bit per stage on all three lanes
    for (genvar j = 0; j <= W; j++)
    begin : g_div
        logic [2:0][REMW-1:0] rsh;
        logic [2:0][REMW-1:0] rem_n;
        logic [2:0][W:0]      q_n;
        logic [REMW-1:0]      dext;
        assign dext = REMW'(dv_d_reg[j]);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsh[i] = {dv_rem_reg[j][i][REMW-2:0], dv_num_reg[j][i][W-j]};
                if (rsh[i] >= dext)
                begin
                    rem_n[i] = rsh[i] - dext;
                    q_n[i]   = {dv_q_reg[j][i][W-1:0], 1'b1};
                end
                else
                begin
                    rem_n[i] = rsh[i];
                    q_n[i]   = {dv_q_reg[j][i][W-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_pay_reg[j+1] <= dv_pay_reg[j];
                dv_d_reg[j+1]   <= dv_d_reg[j];
                dv_dz_reg[j+1]  <= dv_dz_reg[j];
                dv_rem_reg[j+1] <= rem_n;
                dv_q_reg[j+1]   <= q_n;
                dv_num_reg[j+1] <= dv_num_reg[j];
                dv_ovf_reg[j+1] <= dv_ovf_reg[j];
            end
        end
    end

    // sign and saturate the quotients, assemble the result
    always_comb
    begin
        pay_t              pl;
        logic [2:0][W-1:0] rv;
        logic [W:0]        q;
        logic              ng, st;
        pl = dv_pay_reg[W+1];
        rv = pl.r;
        st = pl.st;
        q  = '0;
        ng = 1'b0;
        fin.div_by_zero = 1'b0;
        if (pl.op == vva_pkg::OP_DIV || pl.op == vva_pkg::OP_NORM)
        begin
            st = 1'b0;
            if (dv_dz_reg[W+1])
            begin
                rv = '0;
                fin.div_by_zero = 1'b1;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q  = dv_q_reg[W+1][i];
                    ng = pl.neg_a[i] ^ ((pl.op == vva_pkg::OP_DIV) && pl.scal_neg);
                    if (ng)
                    begin
                        if (dv_ovf_reg[W+1][i] || q[W] || (q[W-1] && (|q[W-2:0])))
                        begin
                            rv[i] = vva_pkg::WMIN;
                            st    = 1'b1;
                        end
                        else
                        begin
                            rv[i] = ~q[W-1:0] + 1'b1;
                        end
                    end
                    else
                    begin
                        if (dv_ovf_reg[W+1][i] || q[W] || q[W-1])
                        begin
                            rv[i] = vva_pkg::WMAX;
                            st    = 1'b1;
                        end
                        else
                        begin
                            rv[i] = q[W-1:0];
                        end
                    end
                end
            end
        end
        fin.rx        = rv[0];
        fin.ry        = rv[1];
        fin.rz        = rv[2];
        fin.rscalar   = pl.rs;
        fin.saturated = st;
    end

    // two-entry result buffer
    assign ob_push     = en && last_v;
    assign empty       = (ob_cnt_reg == 2'd0);
    assign ob_pop      = pop && !empty;
    assign result      = ob_reg[ob_rd_reg];
    assign ob_wr_next  = ob_wr_reg ^ ob_push;
    assign ob_rd_next  = ob_rd_reg ^ ob_pop;
    assign ob_cnt_next = ob_cnt_reg + 2'(ob_push) - 2'(ob_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            ob_wr_reg  <= ob_wr_next;
            ob_rd_reg  <= ob_rd_next;
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_push)
        begin
            ob_reg[ob_wr_reg] <= fin;
        end
    end

endmodule

### hdl/vec3_vector_alu.sv
// Throughput: one item per cycle unless a finished result waits on a full output buffer;
//   every operation takes the same pipeline, whose depth is set by the square root (one
//   bit per stage) and the divider (one quotient bit per stage).
// Reset: rst_n is asynchronous and active low; it empties all queues and pipeline stages.
// ----------------------------------------------------------------------------
// vec3_vector_alu
// Three-component Q16.16 vector ALU: dot, scale, divide, add, subtract,
// negate, length, normalize, cross and clamped lerp, with saturation and
// division-by-zero flags.
// ----------------------------------------------------------------------------
module vec3_vector_alu (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  vva_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output vva_pkg::out_t result
);

    // front side: transfer in, decode opcode and lerp bounds
    logic          cmd_push;
    vva_pkg::cmd_t cmd_wr;
    logic          cmd_full;

    // decoupling queue: lets front and execution stall independently
    vva_pkg::cmd_t cmd_rd;
    logic          cmd_pop;
    logic          cmd_empty;

    vva_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full),
        .cmd      (cmd_wr)
    );

    vva_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    // back side: the execution pipeline advances as a whole and holds only
    // when its last stage has a result and the output buffer is full
    vva_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_rd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### hdl/vva_checker.sv
// ----------------------------------------------------------------------------
// vva_checker
// Port-level checks of the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
module vva_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          push,
    input logic          full,
    input logic          pop,
    input logic          empty,
    input vva_pkg::out_t result
);

    // a zero divisor zeroes the vector and never reports saturation
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.div_by_zero |->
            !result.saturated && result.rx == 0 && result.ry == 0 &&
            result.rz == 0 && result.rscalar == 0)
        else $error("div_by_zero result not clean");

    // scalar results come with a zero vector
    a_scalar_only: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.rscalar != 0 |->
            result.rx == 0 && result.ry == 0 && result.rz == 0)
        else $error("scalar result with nonzero vector");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed before transfer");

endmodule

bind vec3_vector_alu vva_checker u_chk (.*);
